// ===== design/obbo_pkg.sv =====
// Package for the oriented box pair overlap test.
// Holds field widths, the per-lane operand bundle and the lane stage enables.
// No dependencies.
`default_nettype none

package obbo_pkg;

    localparam int EXT_W   = 22;   // half extent, unsigned Q14.8
    localparam int TRIG_W  = 18;   // cosine and sine, signed Q1.16
    localparam int POS_W   = 24;   // centre coordinate, signed Q15.8
    localparam int DPOS_W  = POS_W + 1;    // centre difference
    localparam int AXIS_W  = TRIG_W + 1;   // axis component, may be a negated sine
    localparam int DPROD_W = DPOS_W + AXIS_W;
    localparam int DSUM_W  = DPROD_W + 1;
    localparam int KPROD_W = TRIG_W + AXIS_W;
    localparam int KSUM_W  = KPROD_W + 1;
    localparam int KMAG_W  = KSUM_W - 1;
    localparam int KLO_W   = 18;
    localparam int KHI_W   = KMAG_W - KLO_W;
    localparam int PLO_W   = EXT_W + KLO_W;
    localparam int PHI_W   = EXT_W + KHI_W;
    localparam int TERM_W  = EXT_W + KMAG_W;
    localparam int RSUM_W  = TERM_W + 2;
    localparam int DMAG_W  = DSUM_W;
    localparam int POS_SHIFT = 16;  // centre projection is scaled by 2^16
    localparam int CMP_W   = DMAG_W + POS_SHIFT + 1;
    localparam int NUM_AXES = 4;
    localparam int NUM_STAGES = 9;  // input, seven lane stages, output

    // Operands that one axis lane needs from the input stage.
    typedef struct packed {
        logic signed [DPOS_W-1:0] dx;
        logic signed [DPOS_W-1:0] dy;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [TRIG_W-1:0] a_c;
        logic signed [TRIG_W-1:0] a_s;
        logic signed [TRIG_W-1:0] b_c;
        logic signed [TRIG_W-1:0] b_s;
        logic [EXT_W-1:0]         a_hw;
        logic [EXT_W-1:0]         a_hh;
        logic [EXT_W-1:0]         b_hw;
        logic [EXT_W-1:0]         b_hh;
    } lane_in_t;

    // Load enables for the seven lane stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } lane_en_t;

endpackage

`default_nettype wire

// ===== design/obbo_axis_lane.sv =====
// One separating axis lane: projects the centre difference and both box radii
// onto one axis over seven register stages and flags a gap. Uses obbo_pkg.
`default_nettype none

module obbo_axis_lane
    import obbo_pkg::*;
(
    input  wire logic     clk,
    input  wire lane_in_t din,
    input  wire lane_en_t en,
    output logic          sep
);

    // Stage 1 registers: raw products.
    logic signed [DPROD_W-1:0] pdx_reg, pdy_reg;
    logic signed [KPROD_W-1:0] c_ax_reg [2];
    logic signed [KPROD_W-1:0] s_ay_reg [2];
    logic signed [KPROD_W-1:0] c_ay_reg [2];
    logic signed [KPROD_W-1:0] s_ax_reg [2];
    logic [EXT_W-1:0] ext1_reg [2][2];

    // Stage 2 registers: dot products.
    logic signed [DSUM_W-1:0] d2_reg;
    logic signed [KSUM_W-1:0] k2_reg [2][2];
    logic [EXT_W-1:0] ext2_reg [2][2];

    // Stage 3 registers: magnitudes.
    logic [DMAG_W-1:0] dmag3_reg;
    logic [KMAG_W-1:0] kmag3_reg [2][2];
    logic [EXT_W-1:0] ext3_reg [2][2];

    // Stage 4 registers: split radius products.
    logic [DMAG_W-1:0] dmag4_reg;
    logic [PLO_W-1:0] plo4_reg [2][2];
    logic [PHI_W-1:0] phi4_reg [2][2];

    // Stage 5 and 6 registers: radius terms and their sum.
    logic [DMAG_W-1:0] dmag5_reg, dmag6_reg;
    logic [TERM_W-1:0] term5_reg [2][2];
    logic [RSUM_W-1:0] rsum6_reg;

    // Stage 7 register: separation flag.
    logic sep_reg;

    logic signed [TRIG_W-1:0] cm [2];
    logic signed [TRIG_W-1:0] sm [2];
    logic [EXT_W-1:0] ext_in [2][2];

    always_comb
    begin
        cm[0] = din.a_c;
        sm[0] = din.a_s;
        cm[1] = din.b_c;
        sm[1] = din.b_s;
        ext_in[0][0] = din.a_hw;
        ext_in[0][1] = din.a_hh;
        ext_in[1][0] = din.b_hw;
        ext_in[1][1] = din.b_hh;
    end

    // Stage 1: one product per register.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pdx_reg <= DPROD_W'(din.dx) * DPROD_W'(din.ax);
            pdy_reg <= DPROD_W'(din.dy) * DPROD_W'(din.ay);
            for (int m = 0; m < 2; m++)
            begin
                c_ax_reg[m] <= KPROD_W'(cm[m]) * KPROD_W'(din.ax);
                s_ay_reg[m] <= KPROD_W'(sm[m]) * KPROD_W'(din.ay);
                c_ay_reg[m] <= KPROD_W'(cm[m]) * KPROD_W'(din.ay);
                s_ax_reg[m] <= KPROD_W'(sm[m]) * KPROD_W'(din.ax);
                ext1_reg[m][0] <= ext_in[m][0];
                ext1_reg[m][1] <= ext_in[m][1];
            end
        end
    end

    // Stage 2: centre projection and the axis weights of each box half extent.
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            d2_reg <= DSUM_W'(pdx_reg) + DSUM_W'(pdy_reg);
            for (int m = 0; m < 2; m++)
            begin
                k2_reg[m][0] <= KSUM_W'(c_ax_reg[m]) + KSUM_W'(s_ay_reg[m]);
                k2_reg[m][1] <= KSUM_W'(c_ay_reg[m]) - KSUM_W'(s_ax_reg[m]);
                ext2_reg[m] <= ext1_reg[m];
            end
        end
    end

    // Stage 3: absolute values.
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dmag3_reg <= d2_reg[DSUM_W-1] ? DMAG_W'(-d2_reg) : DMAG_W'(d2_reg);
            for (int m = 0; m < 2; m++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    kmag3_reg[m][j] <= k2_reg[m][j][KSUM_W-1] ?
                                       KMAG_W'(-k2_reg[m][j]) : KMAG_W'(k2_reg[m][j]);
                end
                ext3_reg[m] <= ext2_reg[m];
            end
        end
    end

    // Stage 4: extent times weight, cut into two narrower products.
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            dmag4_reg <= dmag3_reg;
            for (int m = 0; m < 2; m++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    plo4_reg[m][j] <= PLO_W'(ext3_reg[m][j])
                                      * PLO_W'(kmag3_reg[m][j][KLO_W-1:0]);
                    phi4_reg[m][j] <= PHI_W'(ext3_reg[m][j])
                                      * PHI_W'(kmag3_reg[m][j][KMAG_W-1:KLO_W]);
                end
            end
        end
    end

    // Stage 5: recombine the partial products.
    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            dmag5_reg <= dmag4_reg;
            for (int m = 0; m < 2; m++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    term5_reg[m][j] <= (TERM_W'(phi4_reg[m][j]) << KLO_W)
                                       + TERM_W'(plo4_reg[m][j]);
                end
            end
        end
    end

    // Stage 6: total radius of both boxes on this axis.
    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            dmag6_reg <= dmag5_reg;
            rsum6_reg <= (RSUM_W'(term5_reg[0][0]) + RSUM_W'(term5_reg[0][1]))
                       + (RSUM_W'(term5_reg[1][0]) + RSUM_W'(term5_reg[1][1]));
        end
    end

    // Stage 7: a gap exists when the centre distance exceeds the radius sum.
    always_ff @(posedge clk)
    begin
        if (en.s7)
        begin
            sep_reg <= (CMP_W'(dmag6_reg) << POS_SHIFT) > CMP_W'(rsum6_reg);
        end
    end

    assign sep = sep_reg;

endmodule

`default_nettype wire

// ===== design/obb_pair_overlap_test.sv =====
// Overlap test for two oriented 2D boxes by the separating axis test on the four
// local axes of both boxes; touching boxes count as colliding. One pair is taken
// per clock while in_ready is high and passes the input, lane and output stages;
// each stage holds when the one after it is full and stalled, so bubbles are
// squeezed out. Uses obbo_pkg and obbo_axis_lane, one lane per axis.
`default_nettype none

module obb_pair_overlap_test
    import obbo_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [EXT_W-1:0]         a_half_width,
    input  wire logic [EXT_W-1:0]         a_half_height,
    input  wire logic signed [TRIG_W-1:0] a_cos,
    input  wire logic signed [TRIG_W-1:0] a_sin,
    input  wire logic signed [POS_W-1:0]  a_pos_x,
    input  wire logic signed [POS_W-1:0]  a_pos_y,
    input  wire logic [EXT_W-1:0]         b_half_width,
    input  wire logic [EXT_W-1:0]         b_half_height,
    input  wire logic signed [TRIG_W-1:0] b_cos,
    input  wire logic signed [TRIG_W-1:0] b_sin,
    input  wire logic signed [POS_W-1:0]  b_pos_x,
    input  wire logic signed [POS_W-1:0]  b_pos_y,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          collides
);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] en;
    lane_en_t              lane_en;

    // Stage enables: a stage loads when it is empty or its content moves on.
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign lane_en = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4],
                       s5: en[5], s6: en[6], s7: en[7]};

    // Input stage: centre difference and the operands of both boxes.
    logic signed [DPOS_W-1:0] dx_reg, dy_reg;
    logic signed [TRIG_W-1:0] ac_reg, as_reg, bc_reg, bs_reg;
    logic [EXT_W-1:0]         ahw_reg, ahh_reg, bhw_reg, bhh_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg  <= DPOS_W'(b_pos_x) - DPOS_W'(a_pos_x);
            dy_reg  <= DPOS_W'(b_pos_y) - DPOS_W'(a_pos_y);
            ac_reg  <= a_cos;
            as_reg  <= a_sin;
            bc_reg  <= b_cos;
            bs_reg  <= b_sin;
            ahw_reg <= a_half_width;
            ahh_reg <= a_half_height;
            bhw_reg <= b_half_width;
            bhh_reg <= b_half_height;
        end
    end

    // Axis selection: local x and y axes of box A, then of box B.
    lane_in_t lane_in [NUM_AXES];
    logic     sep [NUM_AXES];

    always_comb
    begin
        for (int n = 0; n < NUM_AXES; n++)
        begin
            lane_in[n].dx   = dx_reg;
            lane_in[n].dy   = dy_reg;
            lane_in[n].a_c  = ac_reg;
            lane_in[n].a_s  = as_reg;
            lane_in[n].b_c  = bc_reg;
            lane_in[n].b_s  = bs_reg;
            lane_in[n].a_hw = ahw_reg;
            lane_in[n].a_hh = ahh_reg;
            lane_in[n].b_hw = bhw_reg;
            lane_in[n].b_hh = bhh_reg;
        end
        lane_in[0].ax = AXIS_W'(ac_reg);
        lane_in[0].ay = AXIS_W'(as_reg);
        lane_in[1].ax = -AXIS_W'(as_reg);
        lane_in[1].ay = AXIS_W'(ac_reg);
        lane_in[2].ax = AXIS_W'(bc_reg);
        lane_in[2].ay = AXIS_W'(bs_reg);
        lane_in[3].ax = -AXIS_W'(bs_reg);
        lane_in[3].ay = AXIS_W'(bc_reg);
    end

    for (genvar n = 0; n < NUM_AXES; n++)
    begin : g_lane
        obbo_axis_lane u_lane (
            .clk (clk),
            .din (lane_in[n]),
            .en  (lane_en),
            .sep (sep[n])
        );
    end

    // Output stage: collision unless some axis shows a gap.
    logic collides_reg;

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            collides_reg <= !(sep[0] || sep[1] || sep[2] || sep[3]);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NUM_STAGES-1];
    assign collides  = collides_reg;

`ifndef SYNTH
    // Input back-pressure only arises when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&v_reg))
        else $error("input blocked while a pipeline stage is empty");

    // An accepted transfer occupies the input stage in the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted transfer not held in the input stage");

    // A stalled output keeps the item behind it in place.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && v_reg[NUM_STAGES-2]) |=> v_reg[NUM_STAGES-2])
        else $error("item lost behind a stalled output");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for obb_pair_overlap_test: drives box pairs through the
// valid/ready transfer, predicts the overlap flag by exact separating axis test.
// Depends on obbo_pkg and the obb_pair_overlap_test RTL.
`default_nettype none

module tb;
    import obbo_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [EXT_W-1:0] a_half_width = '0, a_half_height = '0;
    logic signed [TRIG_W-1:0] a_cos = '0, a_sin = '0;
    logic signed [POS_W-1:0] a_pos_x = '0, a_pos_y = '0;
    logic [EXT_W-1:0] b_half_width = '0, b_half_height = '0;
    logic signed [TRIG_W-1:0] b_cos = '0, b_sin = '0;
    logic signed [POS_W-1:0] b_pos_x = '0, b_pos_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic collides;

    typedef struct {
        longint hw, hh, c, s, px, py;
    } box_t;

    bit overlap_expected[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    longint cycle_count = 0;
    localparam longint CYCLE_LIMIT = 400000;

    obb_pair_overlap_test dut (.*);

    // Clock: period of 10 time units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0d] mismatch: %s", cycle_count, what);
    endtask

    // Interval of one box projected on an axis, in Q.40.
    function automatic void project_box(input box_t bx, input longint ax, input longint ay,
                                        output longint lo, output longint hi);
        longint vx, vy, wx, wy, p;
        for (int i = 0; i < 4; i++)
        begin
            vx = (i == 1 || i == 2) ? bx.hw : -bx.hw;
            vy = (i >= 2) ? bx.hh : -bx.hh;
            wx = bx.c * vx - bx.s * vy + bx.px * 65536;
            wy = bx.s * vx + bx.c * vy + bx.py * 65536;
            p = wx * ax + wy * ay;
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endfunction

    function automatic bit axis_separates(input box_t ba, input box_t bb,
                                          input longint ax, input longint ay);
        longint alo, ahi, blo, bhi;
        project_box(ba, ax, ay, alo, ahi);
        project_box(bb, ax, ay, blo, bhi);
        return (ahi < blo) || (bhi < alo);
    endfunction

    function automatic bit predict_overlap(input box_t ba, input box_t bb);
        return !(axis_separates(ba, bb, ba.c, ba.s) || axis_separates(ba, bb, -ba.s, ba.c)
              || axis_separates(ba, bb, bb.c, bb.s) || axis_separates(ba, bb, -bb.s, bb.c));
    endfunction

    // Send one pair, with an optional random gap before it.
    task automatic send_pair(input box_t ba, input box_t bb);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        a_half_width <= EXT_W'(ba.hw); a_half_height <= EXT_W'(ba.hh);
        a_cos <= TRIG_W'(ba.c); a_sin <= TRIG_W'(ba.s);
        a_pos_x <= POS_W'(ba.px); a_pos_y <= POS_W'(ba.py);
        b_half_width <= EXT_W'(bb.hw); b_half_height <= EXT_W'(bb.hh);
        b_cos <= TRIG_W'(bb.c); b_sin <= TRIG_W'(bb.s);
        b_pos_x <= POS_W'(bb.px); b_pos_y <= POS_W'(bb.py);
        in_valid <= 1'b1;
        overlap_expected.push_back(predict_overlap(ba, bb));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver stalls and checks each result transfer.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (overlap_expected.size() == 0)
                report_mismatch("result with nothing expected");
            else if (collides !== overlap_expected.pop_front())
                report_mismatch($sformatf("collides=%b", collides));
        end
    end

    function automatic box_t make_box(longint hw, longint hh, longint c, longint s,
                                      longint px, longint py);
        box_t bx;
        bx.hw = hw; bx.hh = hh; bx.c = c; bx.s = s; bx.px = px; bx.py = py;
        return bx;
    endfunction

    function automatic longint rand_trig();
        case ($urandom_range(5))
            0: return 65536;
            1: return -65536;
            2: return 0;
            3: return -131072 + longint'($urandom_range(131071) * 2);
            default: return longint'($urandom_range(131072)) - 65536;
        endcase
    endfunction

    function automatic longint rand_ext(input bit wide);
        return wide ? longint'($urandom_range(4194303)) : longint'($urandom_range(4095));
    endfunction

    function automatic box_t rand_box(input longint cx, input longint cy, input bit wide);
        return make_box(rand_ext(wide), rand_ext(wide), rand_trig(), rand_trig(),
                        cx, cy);
    endfunction

    // Extremes of every field and the named corner cases.
    task automatic test_directed();
        longint pmax = 8388607, pmin = -8388608, emax = 4194303;
        send_pair(make_box(0, 0, 65536, 0, 0, 0), make_box(0, 0, 65536, 0, 0, 0));
        send_pair(make_box(256, 256, 65536, 0, 0, 0), make_box(256, 256, 65536, 0, 512, 0));
        send_pair(make_box(256, 256, 65536, 0, 0, 0), make_box(256, 256, 65536, 0, 513, 0));
        send_pair(make_box(emax, emax, 65536, 65536, pmax, pmax),
                  make_box(emax, emax, -65536, -65536, pmin, pmin));
        send_pair(make_box(emax, 0, -65536, 65536, pmin, pmax),
                  make_box(0, emax, 65536, -65536, pmax, pmin));
        send_pair(make_box(0, 0, 0, 0, 1000, 0), make_box(10, 10, 65536, 0, 0, 0));
        send_pair(make_box(0, 0, 0, 0, 1000, 0), make_box(0, 0, 0, 0, 0, 0));
        send_pair(make_box(100, 0, 46341, 46341, 0, 0), make_box(0, 100, 46341, -46341, 50, 50));
        send_pair(make_box(1, 1, -131072, 131071, 0, 0), make_box(1, 1, 131071, -131072, 3, 3));
        send_pair(make_box(emax, emax, 0, 0, pmax, pmin), make_box(emax, emax, 0, 0, pmin, pmax));
        send_pair(make_box(256, 0, 65536, 0, 0, 0), make_box(0, 256, 0, 65536, 256, 0));
        send_pair(make_box(300, 100, 56756, 32768, -2000, 700),
                  make_box(200, 400, -32768, 56756, -1800, 900));
    endtask

    // Random pairs, mostly near each other so both outcomes are common.
    task automatic test_random(input int n);
        box_t ba, bb;
        longint cx, cy;
        for (int i = 0; i < n; i++)
        begin
            cx = longint'($urandom_range(16777215)) - 8388608;
            cy = longint'($urandom_range(16777215)) - 8388608;
            if ($urandom_range(9) == 0)
            begin
                ba = rand_box(cx, cy, 1'b1);
                bb = rand_box(longint'($urandom_range(16777215)) - 8388608,
                              longint'($urandom_range(16777215)) - 8388608, 1'b1);
            end
            else
            begin
                if (cx > 8000000) cx = 8000000;
                if (cy > 8000000) cy = 8000000;
                if (cx < -8000000) cx = -8000000;
                if (cy < -8000000) cy = -8000000;
                ba = rand_box(cx, cy, 1'b0);
                bb = rand_box(cx + longint'($urandom_range(16383)) - 8192,
                              cy + longint'($urandom_range(16383)) - 8192, 1'b0);
            end
            send_pair(ba, bb);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle = 25; recv_idle = 51;
        test_directed();
        test_random(500);
        send_idle = 51; recv_idle = 25;
        test_random(500);
        send_idle = 0; recv_idle = 0;
        test_random(530);
        in_valid <= 1'b0;
        while (overlap_expected.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES * 4) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
